// ===== rtl/core/swa_pkg.sv =====
package swa_pkg;

   // width and reset value of the window length register
   localparam int unsigned WLEN_BITS = 5;
   localparam logic [WLEN_BITS-1:0] WINDOW_RESET = 5'd10;

   // commands from the controller to the datapath
   typedef struct packed {
      logic capture;   // latch the sample, pick append or replace and the ring slot
      logic read_old;  // read the ring entry at the chosen slot
      logic update;    // write the ring, update sum, fill and oldest slot, start divide
      logic div_step;  // one restoring divide step
      logic load_out;  // move the quotient into the result register
   } swa_cmd_type;

endpackage

// ===== rtl/core/swa_ram.sv =====
module swa_ram
   import swa_pkg::*;
#(
   parameter int WIDTH     = 12,
   parameter int DEPTH     = 16,
   parameter int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  logic [WIDTH-1:0]     wr_data,
   input  logic                 rd_en,
   input  logic [ADDR_BITS-1:0] rd_addr,
   output logic [WIDTH-1:0]     rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/swa_ctrl.sv =====
module swa_ctrl
   import swa_pkg::*;
#(
   parameter int DIV_STEPS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output swa_cmd_type cmd
);

   localparam int CNT_BITS = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;
   localparam logic [CNT_BITS-1:0] CNT_LAST = CNT_BITS'(DIV_STEPS - 1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_UPDATE,
      ST_DIVIDE,
      ST_FINISH
   } state_type;

   state_type           state_ff, state_in;
   logic [CNT_BITS-1:0] cnt_ff, cnt_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                out_free;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd          = '0;
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_READ;
            end
         end
         ST_READ: begin
            cmd.read_old = 1'b1;
            state_in     = ST_UPDATE;
         end
         ST_UPDATE: begin
            cmd.update = 1'b1;
            cnt_in     = '0;
            state_in   = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + CNT_BITS'(1);
            if (cnt_ff == CNT_LAST) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               cmd.load_out = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ===== rtl/core/swa_datapath.sv =====
module swa_datapath
   import swa_pkg::*;
#(
   parameter int WINDOW_MAX = 16,
   parameter int COORD_BITS = 12
) (
   input  logic                  clock,
   input  logic                  reset,
   input  swa_cmd_type           cmd,
   input  logic [COORD_BITS-1:0] req_coordinate,
   input  logic                  csr_valid,
   input  logic [WLEN_BITS-1:0]  csr_window_length,
   output logic [COORD_BITS-1:0] rsp_average
);

   localparam int SLOT_BITS = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
   localparam int FILL_BITS = $clog2(WINDOW_MAX + 1);
   localparam int IDX_BITS  = FILL_BITS + 1;
   localparam int SUM_BITS  = COORD_BITS + $clog2(WINDOW_MAX);
   localparam int CMP_BITS  = (FILL_BITS > WLEN_BITS) ? FILL_BITS : WLEN_BITS;
   localparam logic [IDX_BITS-1:0] WMAX_IDX = IDX_BITS'(WINDOW_MAX);
   localparam logic [CMP_BITS-1:0] WMAX_CMP = CMP_BITS'(WINDOW_MAX);

   logic [WLEN_BITS-1:0]  wlen_ff;
   logic [COORD_BITS-1:0] sample_ff;
   logic                  append_ff;
   logic [SLOT_BITS-1:0]  slot_ff;
   logic [SUM_BITS-1:0]   sum_ff;
   logic [FILL_BITS-1:0]  fill_ff;
   logic [SLOT_BITS-1:0]  oldest_ff;
   logic [FILL_BITS-1:0]  div_ff;
   logic [FILL_BITS-1:0]  rem_ff;
   logic [SUM_BITS-1:0]   quo_ff;
   logic [COORD_BITS-1:0] avg_ff;

   logic [CMP_BITS-1:0]   eff_len;
   logic [CMP_BITS-1:0]   wlen_ext;
   logic                  append_in;
   logic [IDX_BITS-1:0]   app_idx;
   logic [SLOT_BITS-1:0]  slot_in;
   logic [IDX_BITS-1:0]   next_old_idx;
   logic [SLOT_BITS-1:0]  oldest_in;
   logic [COORD_BITS-1:0] old_sample;
   logic [SUM_BITS-1:0]   sum_in;
   logic [FILL_BITS-1:0]  fill_in;
   logic [FILL_BITS:0]    rem_shift;
   logic                  rem_ge;

   // length register 0 acts as 1, values above the ring depth saturate
   assign wlen_ext = CMP_BITS'(wlen_ff);
   always_comb begin
      if (wlen_ff == '0) begin
         eff_len = CMP_BITS'(1);
      end else if (wlen_ext > WMAX_CMP) begin
         eff_len = WMAX_CMP;
      end else begin
         eff_len = wlen_ext;
      end
   end

   assign append_in = CMP_BITS'(fill_ff) < eff_len;

   // oldest + fill stays below twice the depth, so one subtract wraps it
   assign app_idx = IDX_BITS'(oldest_ff) + IDX_BITS'(fill_ff);
   always_comb begin
      if (!append_in) begin
         slot_in = oldest_ff;
      end else if (app_idx >= WMAX_IDX) begin
         slot_in = SLOT_BITS'(app_idx - WMAX_IDX);
      end else begin
         slot_in = app_idx[SLOT_BITS-1:0];
      end
   end

   assign next_old_idx = IDX_BITS'(slot_ff) + IDX_BITS'(1);
   assign oldest_in    = (next_old_idx == WMAX_IDX) ? '0 : next_old_idx[SLOT_BITS-1:0];

   swa_ram #(
      .WIDTH (COORD_BITS),
      .DEPTH (WINDOW_MAX)
   ) u_ring (
      .clock   (clock),
      .wr_en   (cmd.update),
      .wr_addr (slot_ff),
      .wr_data (sample_ff),
      .rd_en   (cmd.read_old),
      .rd_addr (slot_ff),
      .rd_data (old_sample)
   );

   always_comb begin
      if (append_ff) begin
         sum_in  = sum_ff + SUM_BITS'(sample_ff);
         fill_in = fill_ff + FILL_BITS'(1);
      end else begin
         sum_in  = sum_ff + SUM_BITS'(sample_ff) - SUM_BITS'(old_sample);
         fill_in = fill_ff;
      end
   end

   // restoring divide, one quotient bit per step
   assign rem_shift = {rem_ff, quo_ff[SUM_BITS-1]};
   assign rem_ge    = rem_shift >= {1'b0, div_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         wlen_ff   <= WINDOW_RESET;
         sum_ff    <= '0;
         fill_ff   <= '0;
         oldest_ff <= '0;
      end else begin
         if (csr_valid) begin
            wlen_ff <= csr_window_length;
         end
         if (cmd.update) begin
            sum_ff  <= sum_in;
            fill_ff <= fill_in;
            if (!append_ff) begin
               oldest_ff <= oldest_in;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         sample_ff <= req_coordinate;
         append_ff <= append_in;
         slot_ff   <= slot_in;
      end
      if (cmd.update) begin
         quo_ff <= sum_in;
         rem_ff <= '0;
         div_ff <= fill_in;
      end else if (cmd.div_step) begin
         if (rem_ge) begin
            rem_ff <= FILL_BITS'(rem_shift - {1'b0, div_ff});
         end else begin
            rem_ff <= rem_shift[FILL_BITS-1:0];
         end
         quo_ff <= {quo_ff[SUM_BITS-2:0], rem_ge};
      end
      if (cmd.load_out) begin
         avg_ff <= quo_ff[COORD_BITS-1:0];
      end
   end

   assign rsp_average = avg_ff;

endmodule

// ===== rtl/core/sliding_window_average.sv =====
// moving average over the most recent coordinate samples. each request transfer
// carries one sample and yields exactly one response transfer with the truncated
// mean of the held samples. until window_length samples are held, a sample is
// appended and the divisor is the current fill; after that the oldest sample is
// replaced and the divisor stays at the fill. lowering window_length below the
// fill keeps the fill. a running sum is kept, so each item costs one ring read and
// one ring write. a new request is only accepted while the block is idle, so each
// item runs to its hand-off first: accept, ring read, update, then the restoring
// divider by the fill count, which takes one quotient bit per cycle, and result
// hand-off. the next request is taken while a finished result still waits in the
// output register. write window_length through the csr channel only while the
// block is idle; csr_ready is always high. no clearing pass after reset.
module sliding_window_average
   import swa_pkg::*;
#(
   parameter int WINDOW_MAX = 16,
   parameter int COORD_BITS = 12
) (
   input  logic                  clock,
   input  logic                  reset,
   // request channel
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [COORD_BITS-1:0] req_coordinate,
   // response channel
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [COORD_BITS-1:0] rsp_average,
   // window length register write
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [WLEN_BITS-1:0]  csr_window_length
);

   // the divider runs once per bit of the running sum
   localparam int SUM_BITS = COORD_BITS + $clog2(WINDOW_MAX);

   swa_cmd_type cmd;

   // register writes are never held off
   assign csr_ready = 1'b1;

   // sequencer: accept, ring read, update, divide, hand off
   swa_ctrl #(
      .DIV_STEPS (SUM_BITS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   // sample ring, running sum, fill tracking, divider and result register
   swa_datapath #(
      .WINDOW_MAX (WINDOW_MAX),
      .COORD_BITS (COORD_BITS)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .req_coordinate    (req_coordinate),
      .csr_valid         (csr_valid),
      .csr_window_length (csr_window_length),
      .rsp_average       (rsp_average)
   );

endmodule
